### rtl/errt_pkg.sv
// ----------------------------------------------------------------------------
// errt_pkg
// Shared types and constants of the event report retry table.
// ----------------------------------------------------------------------------
package errt_pkg;

	localparam int CODE_W   = 16;
	localparam int MAC_W    = 48;
	localparam int TIME_W   = 32;
	localparam int MASK_W   = 32;
	localparam int VAL_W    = 32;
	localparam int CNT_W    = 3;
	localparam int PADDR_W  = 6;
	localparam int PDATA_W  = 64;

	localparam logic [TIME_W-1:0] WAIT_TIME_RST   = 32'd60000;
	localparam logic [MASK_W-1:0] ENABLE_MASK_RST = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_ACK   = 2'd1,
		CMD_POLL  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_ALL_ENABLE  = 3'd0,
		REG_ENABLE_MASK = 3'd1,
		REG_ALWAYS_MASK = 3'd2,
		REG_WAIT_TIME   = 3'd3,
		REG_OWN_MAC     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic              all_enable;
		logic [MASK_W-1:0] enable_mask;
		logic [MASK_W-1:0] always_mask;
		logic [TIME_W-1:0] wait_time;
		logic [MAC_W-1:0]  own_mac;
	} cfg_t;

endpackage

### rtl/errt_regs.sv
// ----------------------------------------------------------------------------
// errt_regs
// APB register file holding the enable, masks, wait time and own address.
// ----------------------------------------------------------------------------
module errt_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [errt_pkg::PADDR_W-1:0] paddr,
	input  logic [errt_pkg::PDATA_W-1:0] pwdata,
	output logic [errt_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output errt_pkg::cfg_t               cfg
);
	import errt_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[PADDR_W-1:3];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.all_enable  <= 1'b1;
			cfg_q.enable_mask <= ENABLE_MASK_RST;
			cfg_q.always_mask <= '0;
			cfg_q.wait_time   <= WAIT_TIME_RST;
			cfg_q.own_mac     <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ALL_ENABLE:  cfg_q.all_enable  <= pwdata[0];
				REG_ENABLE_MASK: cfg_q.enable_mask <= pwdata[MASK_W-1:0];
				REG_ALWAYS_MASK: cfg_q.always_mask <= pwdata[MASK_W-1:0];
				REG_WAIT_TIME:   cfg_q.wait_time   <= pwdata[TIME_W-1:0];
				REG_OWN_MAC:     cfg_q.own_mac     <= pwdata[MAC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ALL_ENABLE:  prdata = {{(PDATA_W-1){1'b0}}, cfg_q.all_enable};
			REG_ENABLE_MASK: prdata = {{(PDATA_W-MASK_W){1'b0}}, cfg_q.enable_mask};
			REG_ALWAYS_MASK: prdata = {{(PDATA_W-MASK_W){1'b0}}, cfg_q.always_mask};
			REG_WAIT_TIME:   prdata = {{(PDATA_W-TIME_W){1'b0}}, cfg_q.wait_time};
			REG_OWN_MAC:     prdata = {{(PDATA_W-MAC_W){1'b0}}, cfg_q.own_mac};
			default:         prdata = '0;
		endcase
	end

endmodule

### rtl/event_report_retry_table_unit.sv
// ----------------------------------------------------------------------------
// event_report_retry_table_unit
// Pending event table with add, acknowledge, poll-driven retry and clear.
// ----------------------------------------------------------------------------
// One item is worked on at a time; in_stall stays high until it is done.
// Add, acknowledge and poll scan the table one slot per cycle through a
// single comparator fed by a registered table read, so their cost is set by
// SLOTS. An add stops early at a free slot and an acknowledge at a matching
// slot; a poll that reports is held longer while out_stall holds the result.
// Clear, a dropped add and a poll that is disabled, out of network or
// inside the wait window are done without a scan. Report values beyond the
// stored count read as zero.
module event_report_retry_table_unit #(
	parameter int SLOTS      = 8,
	parameter int MAX_VALUES = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [errt_pkg::PADDR_W-1:0] paddr,
	input  logic [errt_pkg::PDATA_W-1:0] pwdata,
	output logic [errt_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	// input items
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   command,
	input  logic [errt_pkg::TIME_W-1:0]  now_time,
	input  logic [errt_pkg::CODE_W-1:0]  ev_code,
	input  logic [errt_pkg::MASK_W-1:0]  event_mask,
	input  logic [errt_pkg::MAC_W-1:0]   mac,
	input  logic                         mac_given,
	input  logic [errt_pkg::CNT_W-1:0]   value_count,
	input  logic [errt_pkg::VAL_W-1:0]   value_0,
	input  logic [errt_pkg::VAL_W-1:0]   value_1,
	input  logic [errt_pkg::VAL_W-1:0]   value_2,
	input  logic [errt_pkg::VAL_W-1:0]   value_3,
	input  logic                         in_net,
	// result items
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [errt_pkg::CODE_W-1:0]  report_code,
	output logic [errt_pkg::MAC_W-1:0]   report_mac,
	output logic [errt_pkg::CNT_W-1:0]   report_count,
	output logic [errt_pkg::VAL_W-1:0]   report_value_0,
	output logic [errt_pkg::VAL_W-1:0]   report_value_1,
	output logic [errt_pkg::VAL_W-1:0]   report_value_2,
	output logic [errt_pkg::VAL_W-1:0]   report_value_3
);
	import errt_pkg::*;

	localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NV    = (MAX_VALUES < 4) ? MAX_VALUES : 4;
	localparam int ROW_W = NV * VAL_W;
	localparam int CMAX  = (MAX_VALUES > 7) ? 7 : MAX_VALUES;
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(CMAX);
	localparam logic [IW-1:0]    LAST_IDX = IW'(SLOTS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_FETCH,
		ST_REPORT
	} state_t;

	cfg_t cfg;

	errt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// table storage
	logic [CODE_W-1:0] code_mem     [SLOTS];
	logic [MAC_W-1:0]  addr_mem     [SLOTS];
	logic [CNT_W-1:0]  cnt_mem      [SLOTS];
	logic [ROW_W-1:0]  vals_mem     [SLOTS];
	logic [TIME_W-1:0] created_mem  [SLOTS];
	logic [TIME_W-1:0] reported_mem [SLOTS];
	logic [SLOTS-1:0]  valid_q;

	logic [CODE_W-1:0] rd_code_q;
	logic [MAC_W-1:0]  rd_addr_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic [ROW_W-1:0]  rd_vals_q;
	logic [TIME_W-1:0] rd_created_q;
	logic [TIME_W-1:0] rd_reported_q;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [TIME_W-1:0] now_q;
	logic [CODE_W-1:0] code_q;
	logic [MAC_W-1:0]  addr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ROW_W-1:0]  vals_q;
	logic [TIME_W-1:0] wait_stamp_q;
	logic [TIME_W-1:0] best_q;
	logic [IW-1:0]     pick_q;
	logic              found_q;
	logic [IW-1:0]     idx_q;
	logic              iss_act_q;
	logic              cmp_v_s1;
	logic [IW-1:0]     idx_s1;
	logic              last_s1;

	logic              out_valid_q;
	logic [CODE_W-1:0] rep_code_q;
	logic [MAC_W-1:0]  rep_mac_q;
	logic [CNT_W-1:0]  rep_cnt_q;
	logic [ROW_W-1:0]  rep_vals_q;

	logic              accept;
	logic              report_load;
	logic [IW-1:0]     rd_idx;
	logic              add_ok;
	logic              poll_ok;
	logic [TIME_W-1:0] elapsed;
	logic [CNT_W-1:0]  cnt_sat;
	logic [ROW_W-1:0]  vals_in;
	logic [VAL_W-1:0]  in_vals [4];
	logic              poll_hit;

	assign in_stall    = (state_q != ST_IDLE);
	assign accept      = in_valid && (state_q == ST_IDLE);
	assign report_load = (state_q == ST_REPORT) && (!out_valid_q || !out_stall);
	assign rd_idx      = (state_q == ST_SCAN) ? idx_q : pick_q;

	assign add_ok  = cfg.all_enable && ((event_mask & (cfg.enable_mask | cfg.always_mask)) != '0);
	assign elapsed = now_time - wait_stamp_q;
	assign poll_ok = cfg.all_enable && in_net &&
	                 !((wait_stamp_q != '0) && (elapsed < cfg.wait_time));
	assign cnt_sat = (value_count > CNT_MAX) ? CNT_MAX : value_count;

	assign in_vals[0] = value_0;
	assign in_vals[1] = value_1;
	assign in_vals[2] = value_2;
	assign in_vals[3] = value_3;

	always_comb begin
		for (int i = 0; i < NV; i++) begin
			vals_in[i*VAL_W +: VAL_W] = (CNT_W'(i) < cnt_sat) ? in_vals[i] : '0;
		end
	end

	assign poll_hit = valid_q[idx_s1] && (rd_reported_q < best_q);

	// captured item
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd_t'(command);
			now_q  <= now_time;
			code_q <= ev_code;
			addr_q <= mac_given ? mac : cfg.own_mac;
			cnt_q  <= cnt_sat;
			vals_q <= vals_in;
		end
	end

	// table write and registered read
	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) begin
			code_mem[pick_q]     <= code_q;
			addr_mem[pick_q]     <= addr_q;
			cnt_mem[pick_q]      <= cnt_q;
			vals_mem[pick_q]     <= vals_q;
			created_mem[pick_q]  <= now_q;
			reported_mem[pick_q] <= '0;
		end else if (state_q == ST_FETCH) begin
			reported_mem[pick_q] <= now_q;
		end
		rd_code_q     <= code_mem[rd_idx];
		rd_addr_q     <= addr_mem[rd_idx];
		rd_cnt_q      <= cnt_mem[rd_idx];
		rd_vals_q     <= vals_mem[rd_idx];
		rd_created_q  <= created_mem[rd_idx];
		rd_reported_q <= reported_mem[rd_idx];
	end

	// result payload
	always_ff @(posedge clk) begin
		if (report_load) begin
			rep_code_q <= rd_code_q;
			rep_mac_q  <= rd_addr_q;
			rep_cnt_q  <= rd_cnt_q;
			rep_vals_q <= rd_vals_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			wait_stamp_q <= '0;
			out_valid_q  <= 1'b0;
			best_q       <= '0;
			pick_q       <= '0;
			found_q      <= 1'b0;
			idx_q        <= '0;
			iss_act_q    <= 1'b0;
			cmp_v_s1     <= 1'b0;
			idx_s1       <= '0;
			last_s1      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						best_q    <= now_time;
						pick_q    <= '0;
						found_q   <= 1'b0;
						idx_q     <= '0;
						iss_act_q <= 1'b1;
						cmp_v_s1  <= 1'b0;
						unique case (cmd_t'(command))
							CMD_ADD: begin
								if (add_ok) state_q <= ST_SCAN;
							end
							CMD_ACK: begin
								state_q <= ST_SCAN;
							end
							CMD_POLL: begin
								if (poll_ok) state_q <= ST_SCAN;
							end
							CMD_CLEAR: begin
								valid_q <= '0;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (iss_act_q) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == LAST_IDX) iss_act_q <= 1'b0;
					end
					cmp_v_s1 <= iss_act_q;
					idx_s1   <= idx_q;
					last_s1  <= (idx_q == LAST_IDX);
					if (cmp_v_s1) begin
						unique case (cmd_q)
							CMD_ADD: begin
								if (!valid_q[idx_s1]) begin
									pick_q  <= idx_s1;
									state_q <= ST_WRITE;
								end else begin
									if (rd_created_q < best_q) begin
										best_q <= rd_created_q;
										pick_q <= idx_s1;
									end
									if (last_s1) state_q <= ST_WRITE;
								end
							end
							CMD_ACK: begin
								if (valid_q[idx_s1] && (rd_code_q == code_q)) begin
									valid_q[idx_s1] <= 1'b0;
									wait_stamp_q    <= '0;
									state_q         <= ST_IDLE;
								end else if (last_s1) begin
									state_q <= ST_IDLE;
								end
							end
							CMD_POLL: begin
								if (poll_hit) begin
									best_q  <= rd_reported_q;
									pick_q  <= idx_s1;
									found_q <= 1'b1;
								end
								if (last_s1) begin
									state_q <= (found_q || poll_hit) ? ST_FETCH : ST_IDLE;
								end
							end
							CMD_CLEAR: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_WRITE: begin
					valid_q[pick_q] <= 1'b1;
					state_q         <= ST_IDLE;
				end
				ST_FETCH: begin
					wait_stamp_q <= now_q;
					state_q      <= ST_REPORT;
				end
				ST_REPORT: begin
					if (report_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign report_code  = rep_code_q;
	assign report_mac   = rep_mac_q;
	assign report_count = rep_cnt_q;

	logic [VAL_W-1:0] rep_vals [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			rep_vals[i] = '0;
		end
		for (int i = 0; i < NV; i++) begin
			rep_vals[i] = rep_vals_q[i*VAL_W +: VAL_W];
		end
	end

	assign report_value_0 = rep_vals[0];
	assign report_value_1 = rep_vals[1];
	assign report_value_2 = rep_vals[2];
	assign report_value_3 = rep_vals[3];

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: event report retry table
// Drives add, acknowledge, poll and clear items through the valid/stall
// channel, mirrors the eight-slot event table in the testbench and checks
// every report field against the mirrored table. A directed part covers
// saturation, the wait window edge, the mask and enable gates and slot
// replacement. Random phases follow, under several register settings and
// idling patterns.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import errt_pkg::*;

	localparam int SLOTS         = 8;
	localparam int MAX_VALUES    = 4;
	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 16;
	localparam int REG_STRIDE    = 8;
	localparam int TIMEOUT_NS    = 10_000_000;

	typedef struct packed {
		logic [CODE_W-1:0]           code;
		logic [MAC_W-1:0]            mac;
		logic [CNT_W-1:0]            count;
		logic [3:0][VAL_W-1:0]       vals;
	} report_t;

	typedef struct packed {
		cmd_t                        cmd;
		logic [TIME_W-1:0]           now;
		logic [CODE_W-1:0]           code;
		logic [MASK_W-1:0]           emask;
		logic [MAC_W-1:0]            mac;
		logic                        mac_given;
		logic [CNT_W-1:0]            count;
		logic [3:0][VAL_W-1:0]       vals;
		logic                        in_net;
	} event_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]   pwdata = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           command = CMD_ADD;
	logic [TIME_W-1:0]    now_time = '0;
	logic [CODE_W-1:0]    ev_code = '0;
	logic [MASK_W-1:0]    event_mask = '0;
	logic [MAC_W-1:0]     mac = '0;
	logic                 mac_given = 1'b0;
	logic [CNT_W-1:0]     value_count = '0;
	logic [VAL_W-1:0]     value_0 = '0;
	logic [VAL_W-1:0]     value_1 = '0;
	logic [VAL_W-1:0]     value_2 = '0;
	logic [VAL_W-1:0]     value_3 = '0;
	logic                 in_net = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [CODE_W-1:0]    report_code;
	logic [MAC_W-1:0]     report_mac;
	logic [CNT_W-1:0]     report_count;
	logic [VAL_W-1:0]     report_value_0;
	logic [VAL_W-1:0]     report_value_1;
	logic [VAL_W-1:0]     report_value_2;
	logic [VAL_W-1:0]     report_value_3;

	// mirrored table and registers
	cfg_t                  cfg;
	logic                  tbl_valid [SLOTS];
	logic [CODE_W-1:0]     tbl_code [SLOTS];
	logic [MAC_W-1:0]      tbl_mac [SLOTS];
	logic [CNT_W-1:0]      tbl_count [SLOTS];
	logic [3:0][VAL_W-1:0] tbl_vals [SLOTS];
	logic [TIME_W-1:0]     tbl_created [SLOTS];
	logic [TIME_W-1:0]     tbl_reported [SLOTS];
	logic [TIME_W-1:0]     last_report_time;

	report_t               pending_reports [$];
	int                    errors = 0;
	int                    gap_pct = 0;
	int                    stall_pct = 0;
	logic [TIME_W-1:0]     ticks = 32'd1000;

	event_report_retry_table_unit #(
		.SLOTS(SLOTS),
		.MAX_VALUES(MAX_VALUES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.now_time(now_time),
		.ev_code(ev_code),
		.event_mask(event_mask),
		.mac(mac),
		.mac_given(mac_given),
		.value_count(value_count),
		.value_0(value_0),
		.value_1(value_1),
		.value_2(value_2),
		.value_3(value_3),
		.in_net(in_net),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.report_code(report_code),
		.report_mac(report_mac),
		.report_count(report_count),
		.report_value_0(report_value_0),
		.report_value_1(report_value_1),
		.report_value_2(report_value_2),
		.report_value_3(report_value_3)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : report_check
		report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				$display("%0t ns: unexpected report, expected none, actual code %h",
					$time, report_code);
				errors++;
			end else begin
				want = pending_reports.pop_front();
				check_field("report_code", 64'(want.code), 64'(report_code));
				check_field("report_mac", 64'(want.mac), 64'(report_mac));
				check_field("report_count", 64'(want.count), 64'(report_count));
				check_field("report_value_0", 64'(want.vals[0]), 64'(report_value_0));
				check_field("report_value_1", 64'(want.vals[1]), 64'(report_value_1));
				check_field("report_value_2", 64'(want.vals[2]), 64'(report_value_2));
				check_field("report_value_3", 64'(want.vals[3]), 64'(report_value_3));
			end
		end
	end

	// table update for one accepted item; a sending poll queues its report
	task automatic update_event_table(input event_t ev);
		int pick;
		logic [TIME_W-1:0] oldest;
		logic [TIME_W-1:0] elapsed;
		logic [CNT_W-1:0] n;
		report_t rep;
		case (ev.cmd)
			CMD_ADD: begin
				if (cfg.all_enable && (ev.emask & (cfg.enable_mask | cfg.always_mask)) != '0) begin
					n = (ev.count > 3'd4) ? 3'd4 : ev.count;
					pick = 0;
					oldest = ev.now;
					for (int i = 0; i < SLOTS; i++) begin
						if (!tbl_valid[i]) begin
							pick = i;
							break;
						end
						if (tbl_created[i] < oldest) begin
							oldest = tbl_created[i];
							pick = i;
						end
					end
					tbl_valid[pick] = 1'b1;
					tbl_code[pick] = ev.code;
					tbl_mac[pick] = ev.mac_given ? ev.mac : cfg.own_mac;
					tbl_count[pick] = n;
					tbl_created[pick] = ev.now;
					tbl_reported[pick] = '0;
					for (int j = 0; j < MAX_VALUES; j++)
						tbl_vals[pick][j] = (j < n) ? ev.vals[j] : '0;
				end
			end
			CMD_ACK: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (tbl_valid[i] && tbl_code[i] == ev.code) begin
						tbl_valid[i] = 1'b0;
						last_report_time = '0;
						break;
					end
				end
			end
			CMD_POLL: begin
				elapsed = ev.now - last_report_time;
				if (cfg.all_enable && ev.in_net &&
						(last_report_time == '0 || elapsed >= cfg.wait_time)) begin
					pick = -1;
					oldest = ev.now;
					for (int i = 0; i < SLOTS; i++) begin
						if (tbl_valid[i] && tbl_reported[i] < oldest) begin
							oldest = tbl_reported[i];
							pick = i;
						end
					end
					if (pick >= 0) begin
						tbl_reported[pick] = ev.now;
						last_report_time = ev.now;
						rep.code = tbl_code[pick];
						rep.mac = tbl_mac[pick];
						rep.count = tbl_count[pick];
						rep.vals = tbl_vals[pick];
						pending_reports.push_back(rep);
					end
				end
			end
			default: begin
				for (int i = 0; i < SLOTS; i++)
					tbl_valid[i] = 1'b0;
			end
		endcase
	endtask

	task automatic send_event(input event_t ev);
		while ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		command <= ev.cmd;
		now_time <= ev.now;
		ev_code <= ev.code;
		event_mask <= ev.emask;
		mac <= ev.mac;
		mac_given <= ev.mac_given;
		value_count <= ev.count;
		value_0 <= ev.vals[0];
		value_1 <= ev.vals[1];
		value_2 <= ev.vals[2];
		value_3 <= ev.vals[3];
		in_net <= ev.in_net;
		do @(posedge clk); while (in_stall);
		update_event_table(ev);
	endtask

	task automatic send_directed(input cmd_t cmd, input logic [TIME_W-1:0] now,
			input logic [CODE_W-1:0] code = '0, input logic [CNT_W-1:0] count = '0,
			input logic [VAL_W-1:0] fill = '0, input logic given = 1'b0,
			input logic [MAC_W-1:0] addr = '0, input logic [MASK_W-1:0] emask = '1,
			input logic net = 1'b1);
		event_t ev;
		ev.cmd = cmd;
		ev.now = now;
		ev.code = code;
		ev.count = count;
		ev.vals = {fill + 32'd3, fill + 32'd2, fill + 32'd1, fill};
		ev.mac_given = given;
		ev.mac = addr;
		ev.emask = emask;
		ev.in_net = net;
		send_event(ev);
	endtask

	task automatic send_random_event();
		event_t ev;
		int roll;
		logic [CODE_W-1:0] live [$];
		roll = $urandom_range(99);
		if (roll < 90)
			ticks += $urandom_range(1, 30);
		else if (roll < 96)
			ticks = $urandom;
		ev.now = ticks;
		if ($urandom_range(99) < 4)
			ev.now = $urandom;
		roll = $urandom_range(99);
		if (roll < 38)
			ev.cmd = CMD_ADD;
		else if (roll < 58)
			ev.cmd = CMD_ACK;
		else if (roll < 97)
			ev.cmd = CMD_POLL;
		else
			ev.cmd = CMD_CLEAR;
		ev.code = ($urandom_range(99) < 80) ? CODE_W'($urandom_range(11)) : CODE_W'($urandom);
		for (int i = 0; i < SLOTS; i++)
			if (tbl_valid[i])
				live.push_back(tbl_code[i]);
		if (ev.cmd == CMD_ACK && live.size() != 0 && $urandom_range(99) < 75)
			ev.code = live[$urandom_range(live.size() - 1)];
		roll = $urandom_range(99);
		if (roll < 70)
			ev.emask = $urandom;
		else if (roll < 90)
			ev.emask = 32'h1 << $urandom_range(31);
		else
			ev.emask = '0;
		ev.mac = {16'($urandom), 32'($urandom)};
		ev.mac_given = 1'($urandom_range(1));
		ev.count = ($urandom_range(99) < 80) ? CNT_W'($urandom_range(4)) :
			CNT_W'($urandom_range(7, 5));
		for (int j = 0; j < 4; j++)
			ev.vals[j] = $urandom;
		ev.in_net = ($urandom_range(99) < 90);
		send_event(ev);
	endtask

	// waits out the last report and any item still at work
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] data);
		logic [PDATA_W-1:0] want;
		case (idx)
			REG_ALL_ENABLE: begin
				cfg.all_enable = data[0];
				want = PDATA_W'(data[0]);
			end
			REG_ENABLE_MASK: begin
				cfg.enable_mask = data[MASK_W-1:0];
				want = PDATA_W'(data[MASK_W-1:0]);
			end
			REG_ALWAYS_MASK: begin
				cfg.always_mask = data[MASK_W-1:0];
				want = PDATA_W'(data[MASK_W-1:0]);
			end
			REG_WAIT_TIME: begin
				cfg.wait_time = data[TIME_W-1:0];
				want = PDATA_W'(data[TIME_W-1:0]);
			end
			default: begin
				cfg.own_mac = data[MAC_W-1:0];
				want = PDATA_W'(data[MAC_W-1:0]);
			end
		endcase
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(int'(idx) * REG_STRIDE);
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("prdata", want, prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input logic en, input logic [MASK_W-1:0] emask,
			input logic [MASK_W-1:0] amask, input logic [TIME_W-1:0] wtime,
			input logic [MAC_W-1:0] own);
		settle();
		write_reg(REG_ALL_ENABLE, PDATA_W'(en));
		write_reg(REG_ENABLE_MASK, PDATA_W'(emask));
		write_reg(REG_ALWAYS_MASK, PDATA_W'(amask));
		write_reg(REG_WAIT_TIME, PDATA_W'(wtime));
		write_reg(REG_OWN_MAC, PDATA_W'(own));
	endtask

	task automatic run_random(input int count, input int gap, input int stall);
		logic quiet;
		for (int k = 0; k < count; k++) begin
			quiet = ((k / 40) % 4 == 3);
			gap_pct = quiet ? 0 : gap;
			stall_pct = quiet ? 0 : stall;
			send_random_event();
		end
	endtask

	task automatic test_reset_settings();
		send_directed(CMD_ADD, 32'd10, 16'd1, 3'd7, 32'hFFFF_FFFF, 1'b0, '1);
		send_directed(CMD_POLL, 32'd0);
		send_directed(CMD_POLL, 32'd20, '0, '0, '0, 1'b0, '0, '1, 1'b0);
		send_directed(CMD_POLL, 32'd20);
		send_directed(CMD_ACK, 32'd25, 16'd1);
		send_directed(CMD_ACK, 32'd26, 16'd1);
		send_directed(CMD_ADD, 32'd40, 16'hFFFF, 3'd0, 32'hFFFF_FFFF, 1'b1, '1);
		send_directed(CMD_ADD, 32'd41, 16'd0, 3'd2, 32'h1234_5678, 1'b1, '0, 32'h8000_0000);
		send_directed(CMD_POLL, 32'd50);
		// window edge: 60000 ticks after the stamp at 50
		send_directed(CMD_POLL, 32'd60049);
		send_directed(CMD_POLL, 32'd60050);
		send_directed(CMD_CLEAR, 32'd60060);
		send_directed(CMD_POLL, 32'd200000);
	endtask

	task automatic test_full_table();
		set_config(1'b1, '1, '0, '0, '1);
		for (int k = 0; k < SLOTS; k++)
			send_directed(CMD_ADD, 32'd100 + k, CODE_W'(16'h0010 + k), CNT_W'(k % 5),
				32'hA5A5_0000 + k);
		// nothing older than now: slot 0 goes
		send_directed(CMD_ADD, 32'd50, 16'h0020, 3'd4, 32'h5555_0000);
		send_directed(CMD_POLL, 32'd300);
	endtask

	task automatic test_enable_gates();
		set_config(1'b0, '1, '0, '0, 48'h0123_4567_89AB);
		send_directed(CMD_ADD, 32'd400, 16'h0030, 3'd1, 32'd7);
		send_directed(CMD_POLL, 32'd500);
		set_config(1'b1, '0, '0, '0, 48'h0123_4567_89AB);
		send_directed(CMD_ADD, 32'd600, 16'h0031, 3'd1, 32'd8);
		set_config(1'b1, '0, 32'h8000_0000, '0, 48'h0123_4567_89AB);
		send_directed(CMD_ADD, 32'd700, 16'h0032, 3'd3, 32'd9, 1'b0, '0, 32'h8000_0000);
	endtask

	task automatic test_random_no_wait();
		set_config(1'b1, '1, '0, '0, {16'($urandom), 32'($urandom)});
		run_random(300, 0, 0);
	endtask

	task automatic test_random_short_wait();
		set_config(1'b1, $urandom, $urandom, 32'd25, {16'($urandom), 32'($urandom)});
		run_random(300, 77, 0);
	endtask

	task automatic test_random_long_wait();
		set_config(1'b1, '0, '1, 32'd400, '1);
		run_random(300, 0, 77);
	endtask

	task automatic test_random_max_wait();
		set_config(1'b1, $urandom, '0, '1, '0);
		run_random(200, 21, 21);
	endtask

	task automatic test_random_disabled();
		set_config(1'b0, '1, '1, '0, '1);
		run_random(100, 21, 21);
	endtask

	task automatic test_random_mixed();
		set_config(1'b1, '1, $urandom, $urandom_range(100), {16'($urandom), 32'($urandom)});
		run_random(75, 0, 0);
		run_random(75, 77, 0);
		run_random(75, 0, 77);
		run_random(75, 21, 21);
	endtask

	initial begin
		cfg.all_enable = 1'b1;
		cfg.enable_mask = ENABLE_MASK_RST;
		cfg.always_mask = '0;
		cfg.wait_time = WAIT_TIME_RST;
		cfg.own_mac = '0;
		for (int i = 0; i < SLOTS; i++)
			tbl_valid[i] = 1'b0;
		last_report_time = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_settings();
		test_full_table();
		test_enable_gates();
		test_random_no_wait();
		test_random_short_wait();
		test_random_long_wait();
		test_random_max_wait();
		test_random_disabled();
		test_random_mixed();

		settle();
		if (errors == 0)
			$display("event_report_retry_table_unit test passed");
		else
			$display("event_report_retry_table_unit test failed");
		$finish;
	end

	initial begin
		#TIMEOUT_NS;
		$display("event_report_retry_table_unit test failed");
		$finish;
	end

endmodule

### sim.f
rtl/errt_pkg.sv
rtl/errt_regs.sv
rtl/event_report_retry_table_unit.sv
test/tb.sv
